>>> rtl/ring_descriptor_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef RING_DESCRIPTOR_ALLOCATOR_MACROS_SVH
`define RING_DESCRIPTOR_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RDA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring descriptor allocator: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define RDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring descriptor allocator: next-cycle check failed");

`endif

>>> rtl/rda_pkg.sv
// Field widths, request codes, status codes and state encoding of the ring descriptor allocator.
`timescale 1ns / 1ps

package rda_pkg;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int LINK_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;
  localparam int ALLOC_N  = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC3 = 2'd0,
    FN_FREE   = 2'd1,
    FN_LINK   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_ALREADY  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_WALK  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

endpackage

>>> rtl/rda_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rda_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ring_descriptor_allocator.sv
// Ring descriptor allocator: free map, link table and request sequencer.
//
// Use: one request channel (in_valid/in_stall) carries func, index, has_next
// and next_index; one result channel (out_valid/out_stall) carries status,
// the three allocated indices and freed_count. Every request gives exactly
// one result beat. A beat is taken on an edge with valid high and stall low.
// Requests are worked one at a time; in_stall is high while one is in work.
// Steps from the accepting edge to the edge that loads the result:
//   allocate three: 3 scan steps of a lowest-free priority encoder over
//     the free map, then the result load; fewer scan steps when the map
//     holds fewer than two free entries;
//   write link and the unused code: the result load only;
//   free chain: per freed entry a check step and a link-table RAM read
//     step, then the result load, plus one more check step on an error.
// The next request can be taken in the cycle after the result load.
// The link table sits in a RAM of TABLE_SIZE x 4 bits; a valid bit per entry
// stands for its cleared reset value, so no clearing pass is needed.
// Reset marks every entry free and every link cleared, and empties the
// output register. A stalled result holds in the output register; a
// finished request waits in its final step until that register frees up.
`timescale 1ns / 1ps

`include "ring_descriptor_allocator_macros.svh"

module ring_descriptor_allocator #(
  parameter int TABLE_SIZE = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rda_pkg::FUNC_W-1:0]     func,
  input  logic [rda_pkg::INDEX_W-1:0]    index,
  input  logic                           has_next,
  input  logic [rda_pkg::LINK_W-1:0]     next_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rda_pkg::STATUS_W-1:0]   status,
  output logic [rda_pkg::LINK_W-1:0]     first_index,
  output logic [rda_pkg::LINK_W-1:0]     second_index,
  output logic [rda_pkg::LINK_W-1:0]     third_index,
  output logic [rda_pkg::COUNT_W-1:0]    freed_count
);

  import rda_pkg::*;

  localparam int AW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int LDATA_W = LINK_W + 1;

  state_t                state;
  logic [TABLE_SIZE-1:0] free_map;
  logic [TABLE_SIZE-1:0] link_valid;
  logic [TABLE_SIZE-1:0] scan;
  logic [1:0]            alloc_n;
  logic [AW-1:0]         pick0;
  logic [AW-1:0]         pick1;
  logic [AW-1:0]         pick2;
  logic [INDEX_W-1:0]    cur;
  logic [COUNT_W-1:0]    freed;
  status_t               res_status;

  logic                  low_any;
  logic [AW-1:0]         low_idx;
  logic [TABLE_SIZE-1:0] scan_next;
  logic [AW-1:0]         cur_a;
  logic                  cur_in_range;
  logic                  index_in_range;
  logic                  in_accept;
  logic                  out_free;
  logic                  link_we;
  logic [LDATA_W-1:0]    link_rdata;
  logic                  link_more;

  // lowest set bit of the scan mask
  always_comb begin
    low_any = 1'b0;
    low_idx = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (scan[i]) begin
        low_any = 1'b1;
        low_idx = AW'(i);
      end
    end
    scan_next = scan;
    scan_next[low_idx] = 1'b0;
  end

  assign cur_a          = AW'(cur);
  assign cur_in_range   = int'(cur) < TABLE_SIZE;
  assign index_in_range = int'(index) < TABLE_SIZE;
  assign in_stall       = (state != S_IDLE);
  assign in_accept      = in_valid && !in_stall;
  assign out_free       = !out_valid || !out_stall;
  assign link_we        = in_accept && (func_t'(func) == FN_LINK) && index_in_range;
  assign link_more      = link_valid[cur_a] && link_rdata[LINK_W];

  rda_ram #(
    .WIDTH (LDATA_W),
    .DEPTH (TABLE_SIZE)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (AW'(index)),
    .wdata ({has_next, next_index}),
    .raddr (cur_a),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_map   <= '1;
      link_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_status <= ST_OK;
            pick0      <= '0;
            pick1      <= '0;
            pick2      <= '0;
            freed      <= '0;
            cur        <= index;
            scan       <= free_map;
            alloc_n    <= '0;
            unique case (func_t'(func))
              FN_ALLOC3: state <= S_ALLOC;
              FN_FREE:   state <= S_WALK;
              FN_LINK: begin
                if (index_in_range) begin
                  link_valid[AW'(index)] <= 1'b1;
                end else begin
                  res_status <= ST_RANGE;
                end
                state <= S_RESP;
              end
              default:   state <= S_RESP;
            endcase
          end
        end
        S_ALLOC: begin
          if (!low_any) begin
            res_status <= ST_NO_SPACE;
            pick0      <= '0;
            pick1      <= '0;
            pick2      <= '0;
            state      <= S_RESP;
          end else begin
            scan    <= scan_next;
            alloc_n <= alloc_n + 2'd1;
            case (alloc_n)
              2'd0:    pick0 <= low_idx;
              2'd1:    pick1 <= low_idx;
              default: pick2 <= low_idx;
            endcase
            if (alloc_n == 2'(ALLOC_N - 1)) begin
              // commit: the scan mask is the free map less the three picks
              free_map <= scan_next;
              state    <= S_RESP;
            end
          end
        end
        S_WALK: begin
          if (!cur_in_range) begin
            res_status <= ST_RANGE;
            state      <= S_RESP;
          end else if (free_map[cur_a]) begin
            res_status <= ST_ALREADY;
            state      <= S_RESP;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // release the entry; clearing its valid bit clears its link
          free_map[cur_a]   <= 1'b1;
          link_valid[cur_a] <= 1'b0;
          freed             <= freed + COUNT_W'(1);
          if (link_more) begin
            cur   <= INDEX_W'(link_rdata[LINK_W-1:0]);
            state <= S_WALK;
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            first_index  <= LINK_W'(pick0);
            second_index <= LINK_W'(pick1);
            third_index  <= LINK_W'(pick2);
            freed_count  <= freed;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RDA_ASSERT_IMPL(a_alloc_step, state == S_ALLOC, alloc_n <= 2'(ALLOC_N - 1))
  `RDA_ASSERT_IMPL(a_wait_in_range, state == S_WAIT, int'(cur) < TABLE_SIZE)
  `RDA_ASSERT_IMPL(a_no_space_zero, out_valid && status == ST_NO_SPACE,
                   first_index == '0 && second_index == '0 && third_index == '0)
  `RDA_ASSERT_NEXT(a_alloc_commit,
                   state == S_ALLOC && alloc_n == 2'(ALLOC_N - 1) && low_any,
                   $countones(free_map) == $countones($past(free_map)) - ALLOC_N)

endmodule
